>>> rtl/fcgi_pkg.sv
// Shared types and constants for the FastCGI name-value pair parser.
// No dependencies; imported by the front parser, the result queue and the top level.
package fcgi_pkg;

    // Parse phases. Codes 6 and 7 are unused and decode as PH_NLEN.
    typedef enum logic [2:0] {
        PH_NLEN      = 3'd0,
        PH_NLEN_MORE = 3'd1,
        PH_VLEN      = 3'd2,
        PH_VLEN_MORE = 3'd3,
        PH_NAME      = 3'd4,
        PH_VALUE     = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_LEN   = 2'd0,
        ROLE_NAME  = 2'd1,
        ROLE_VALUE = 2'd2
    } t_role;

    typedef struct packed {
        logic lengths_valid;
        logic field_last;
        logic pair_done;
    } t_marks;

    // A long length field is shifted in at this width (top bit of first byte masked).
    localparam int ASM_BITS      = 31;
    localparam int LEN_IDX_BITS  = 2;
    localparam int BYTE_BITS     = 8;

    // Result queue; depth must be a power of two so pointers wrap naturally.
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

endpackage

>>> rtl/fcgi_front.sv
// Front end: classifies each params byte and tracks the pair parse state.
// Depends on fcgi_pkg. Produces one result word per accepted byte.
module fcgi_front import fcgi_pkg::*; #(
    parameter int LENGTH_BITS = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [BYTE_BITS-1:0]   i_byte,
    output t_role                  o_role,
    output t_marks                 o_marks,
    output logic [LENGTH_BITS-1:0] o_name_length,
    output logic [LENGTH_BITS-1:0] o_value_length
);

    localparam logic [ASM_BITS-1:0] LEN_MAX = ASM_BITS'((64'd1 << LENGTH_BITS) - 64'd1);

    t_phase                  r_phase, n_phase, ph_eff;
    logic [LEN_IDX_BITS-1:0] r_idx, n_idx, idx_inc;
    logic [ASM_BITS-1:0]     r_asm, n_asm, asm_shift;
    logic [LENGTH_BITS-1:0]  r_held_name, n_held_name;
    logic [LENGTH_BITS-1:0]  r_held_value, n_held_value;
    logic [LENGTH_BITS-1:0]  r_rem, n_rem, rem_dec, len_val;
    logic                    first_byte, len_done, rem_last;

    always_comb begin
        case (r_phase)
            PH_NLEN, PH_NLEN_MORE, PH_VLEN, PH_VLEN_MORE, PH_NAME, PH_VALUE: ph_eff = r_phase;
            default: ph_eff = PH_NLEN;
        endcase
    end

    // Length field decode shared by name and value lengths
    assign first_byte = (ph_eff == PH_NLEN) || (ph_eff == PH_VLEN);
    assign idx_inc    = r_idx + 1'b1;
    assign asm_shift  = {r_asm[ASM_BITS-BYTE_BITS-1:0], i_byte};
    assign len_done   = first_byte ? ~i_byte[BYTE_BITS-1] : (idx_inc == '0);
    assign len_val    = first_byte ? LENGTH_BITS'(i_byte[BYTE_BITS-2:0])
                      : (asm_shift > LEN_MAX) ? LEN_MAX[LENGTH_BITS-1:0]
                      : asm_shift[LENGTH_BITS-1:0];

    // Data byte countdown; a zero count is taken as the last byte
    assign rem_dec  = (r_rem != '0) ? r_rem - 1'b1 : '0;
    assign rem_last = (rem_dec == '0);

    // Next state
    always_comb begin
        n_phase      = ph_eff;
        n_idx        = r_idx;
        n_asm        = r_asm;
        n_held_name  = r_held_name;
        n_held_value = r_held_value;
        n_rem        = r_rem;
        case (ph_eff)
            PH_NLEN, PH_NLEN_MORE, PH_VLEN, PH_VLEN_MORE: begin
                if (len_done) begin
                    n_idx = '0;
                    n_asm = '0;
                end else if (first_byte) begin
                    n_idx = LEN_IDX_BITS'(1);
                    n_asm = ASM_BITS'(i_byte[BYTE_BITS-2:0]);
                end else begin
                    n_idx = idx_inc;
                    n_asm = asm_shift;
                end
                if (ph_eff == PH_NLEN) begin
                    n_held_name  = '0;
                    n_held_value = '0;
                end
                if (ph_eff == PH_NLEN || ph_eff == PH_NLEN_MORE) begin
                    if (len_done) begin
                        n_held_name = len_val;
                        n_phase     = PH_VLEN;
                    end else begin
                        n_phase = PH_NLEN_MORE;
                    end
                end else begin
                    if (len_done) begin
                        n_held_value = len_val;
                        if (r_held_name != '0) begin
                            n_rem   = r_held_name;
                            n_phase = PH_NAME;
                        end else if (len_val != '0) begin
                            n_rem   = len_val;
                            n_phase = PH_VALUE;
                        end else begin
                            n_phase = PH_NLEN;
                        end
                    end else begin
                        n_phase = PH_VLEN_MORE;
                    end
                end
            end
            PH_NAME: begin
                n_rem = rem_dec;
                if (rem_last) begin
                    if (r_held_value != '0) begin
                        n_rem   = r_held_value;
                        n_phase = PH_VALUE;
                    end else begin
                        n_phase = PH_NLEN;
                    end
                end
            end
            PH_VALUE: begin
                n_rem = rem_dec;
                if (rem_last) begin
                    n_phase = PH_NLEN;
                end
            end
            default: begin
                n_phase = PH_NLEN;
            end
        endcase
    end

    // Result fields
    always_comb begin
        o_role                = ROLE_LEN;
        o_marks.lengths_valid = 1'b0;
        o_marks.field_last    = 1'b0;
        o_marks.pair_done     = 1'b0;
        case (ph_eff)
            PH_VLEN, PH_VLEN_MORE: begin
                o_marks.lengths_valid = len_done;
                o_marks.pair_done     = len_done && (r_held_name == '0) && (len_val == '0);
            end
            PH_NAME: begin
                o_role             = ROLE_NAME;
                o_marks.field_last = rem_last;
                o_marks.pair_done  = rem_last && (r_held_value == '0);
            end
            PH_VALUE: begin
                o_role             = ROLE_VALUE;
                o_marks.field_last = rem_last;
                o_marks.pair_done  = rem_last;
            end
            default: begin
                o_role = ROLE_LEN;
            end
        endcase
    end

    assign o_name_length  = n_held_name;
    assign o_value_length = n_held_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_NLEN;
            r_idx        <= '0;
            r_asm        <= '0;
            r_held_name  <= '0;
            r_held_value <= '0;
            r_rem        <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_asm        <= n_asm;
            r_held_name  <= n_held_name;
            r_held_value <= n_held_value;
            r_rem        <= n_rem;
        end
    end

endmodule

>>> rtl/fcgi_queue.sv
// Back end: short result queue that holds finished results until taken downstream.
// Depends on fcgi_pkg for depth and pointer widths.
module fcgi_queue import fcgi_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]       r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/fastcgi_param_pair_parser.sv
// Top level of the FastCGI PARAMS name-value pair parser.
// Depends on fcgi_pkg, fcgi_front and fcgi_queue.
//
// Takes one params byte per cycle while the input is not stalled and returns one
// result word per byte: its role (length, name or value byte), the byte, the
// decoded name and value lengths of the current pair, and marks for length
// completion, field end and pair end. Lengths wider than LENGTH_BITS saturate.
// Each result word is queued when its byte is accepted; the parser state updates
// on every accepted byte, so a byte can be accepted every cycle. A two-word queue
// sits between parser and output; input is stalled only when it holds both words.
module fastcgi_param_pair_parser import fcgi_pkg::*; #(
    parameter int LENGTH_BITS = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [BYTE_BITS-1:0]   i_in_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_byte_role,
    output logic [BYTE_BITS-1:0]   o_out_byte,
    output logic [LENGTH_BITS-1:0] o_name_length,
    output logic [LENGTH_BITS-1:0] o_value_length,
    output logic                   o_lengths_valid,
    output logic                   o_field_last,
    output logic                   o_pair_done
);

    localparam int DATA_W = $bits(t_role) + BYTE_BITS + $bits(t_marks) + 2 * LENGTH_BITS;

    logic                   in_accept, out_accept, q_full;
    t_role                  f_role;
    t_marks                 f_marks, q_marks;
    logic [LENGTH_BITS-1:0] f_name_length, f_value_length;
    logic [DATA_W-1:0]      q_in, q_out;

    assign in_accept  = i_in_valid && !q_full;
    assign o_in_stall = q_full;
    assign out_accept = o_out_valid && !i_out_stall;

    fcgi_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_byte         (i_in_byte),
        .o_role         (f_role),
        .o_marks        (f_marks),
        .o_name_length  (f_name_length),
        .o_value_length (f_value_length)
    );

    assign q_in = {f_role, i_in_byte, f_marks, f_name_length, f_value_length};

    fcgi_queue #(
        .WIDTH (DATA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_pop   (out_accept),
        .o_data  (q_out)
    );

    assign {o_byte_role, o_out_byte, q_marks, o_name_length, o_value_length} = q_out;
    assign o_lengths_valid = q_marks.lengths_valid;
    assign o_field_last    = q_marks.field_last;
    assign o_pair_done     = q_marks.pair_done;

    // A full queue always has a word to offer.
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_field_last) |-> (o_byte_role != ROLE_LEN))
        else $error("field end on a length byte");

    a_lv_is_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_lengths_valid) |-> (o_byte_role == ROLE_LEN))
        else $error("lengths completed on a data byte");

    // A pair ends on a length byte only when both fields are empty.
    a_done_on_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pair_done && o_byte_role == ROLE_LEN) |->
        (o_lengths_valid && o_name_length == '0 && o_value_length == '0))
        else $error("pair end on a length byte with nonempty fields");

    a_value_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pair_done && o_byte_role == ROLE_VALUE) |-> o_field_last)
        else $error("pair end on a value byte that is not the field end");

endmodule

>>> verif/fastcgi_param_pair_checker.sv
// Checker for the FastCGI name-value pair parser: watches both channels, tracks the parse
// state byte by byte and compares every result word with the word it should be.
// Depends on fcgi_pkg.
module fastcgi_param_pair_checker import fcgi_pkg::*; #(
    parameter int LENGTH_BITS = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   o_in_stall,
    input  logic [BYTE_BITS-1:0]   i_in_byte,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  logic [1:0]             o_byte_role,
    input  logic [BYTE_BITS-1:0]   o_out_byte,
    input  logic [LENGTH_BITS-1:0] o_name_length,
    input  logic [LENGTH_BITS-1:0] o_value_length,
    input  logic                   o_lengths_valid,
    input  logic                   o_field_last,
    input  logic                   o_pair_done,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_words_checked,
    output int                     o_pairs_done
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_role                role;
        logic [BYTE_BITS-1:0] data;
        logic [30:0]          name_len;
        logic [30:0]          value_len;
        t_marks               marks;
    } t_parse_word;

    t_parse_word expected_words [$];

    t_phase      phase_q;
    logic [1:0]  idx_q;
    logic [30:0] asm_q;
    logic [30:0] name_len_q;
    logic [30:0] value_len_q;
    logic [30:0] remain_q;
    int          fail_total;
    int          words_total;
    int          pairs_total;

    // Shifts one byte into a length field; returns 1 once the field is complete.
    function automatic logic take_length_byte(input logic [7:0] b, input logic first,
                                              output logic [30:0] len);
        logic        done;
        logic [31:0] lmax;
        lmax = (32'd1 << LENGTH_BITS) - 32'd1;
        done = 1'b0;
        len  = '0;
        if (first) begin
            if (!b[7]) begin
                len  = {23'd0, b};
                done = 1'b1;
            end else begin
                asm_q = {24'd0, b[6:0]};
                idx_q = 2'd1;
            end
        end else begin
            asm_q = {asm_q[22:0], b};
            idx_q = idx_q + 2'd1;
            if (idx_q == 2'd0) begin
                len   = ({1'b0, asm_q} > lmax) ? lmax[30:0] : asm_q;
                asm_q = '0;
                done  = 1'b1;
            end
        end
        take_length_byte = done;
    endfunction

    function automatic t_parse_word parse_byte(input logic [7:0] b);
        t_parse_word w;
        t_phase      ph;
        logic [30:0] len;
        logic        got;
        w      = '0;
        w.role = ROLE_LEN;
        w.data = b;
        ph     = phase_q;
        // unused phase codes fall back to the name length phase
        if (ph > PH_VALUE) ph = PH_NLEN;
        case (ph)
            PH_NLEN, PH_NLEN_MORE: begin
                if (ph == PH_NLEN) begin
                    name_len_q  = '0;
                    value_len_q = '0;
                    idx_q       = '0;
                    asm_q       = '0;
                end
                got = take_length_byte(b, ph == PH_NLEN, len);
                if (got) begin
                    name_len_q = len;
                    phase_q    = PH_VLEN;
                end else begin
                    phase_q = PH_NLEN_MORE;
                end
            end
            PH_VLEN, PH_VLEN_MORE: begin
                if (ph == PH_VLEN) begin
                    idx_q = '0;
                    asm_q = '0;
                end
                got = take_length_byte(b, ph == PH_VLEN, len);
                if (got) begin
                    value_len_q           = len;
                    w.marks.lengths_valid = 1'b1;
                    if (name_len_q != 0) begin
                        remain_q = name_len_q;
                        phase_q  = PH_NAME;
                    end else if (value_len_q != 0) begin
                        remain_q = value_len_q;
                        phase_q  = PH_VALUE;
                    end else begin
                        w.marks.pair_done = 1'b1;
                        phase_q           = PH_NLEN;
                    end
                end else begin
                    phase_q = PH_VLEN_MORE;
                end
            end
            PH_NAME: begin
                w.role = ROLE_NAME;
                if (remain_q != 0) remain_q = remain_q - 31'd1;
                if (remain_q == 0) begin
                    w.marks.field_last = 1'b1;
                    if (value_len_q != 0) begin
                        remain_q = value_len_q;
                        phase_q  = PH_VALUE;
                    end else begin
                        w.marks.pair_done = 1'b1;
                        phase_q           = PH_NLEN;
                    end
                end
            end
            default: begin
                w.role = ROLE_VALUE;
                if (remain_q != 0) remain_q = remain_q - 31'd1;
                if (remain_q == 0) begin
                    w.marks.field_last = 1'b1;
                    w.marks.pair_done  = 1'b1;
                    phase_q            = PH_NLEN;
                end
            end
        endcase
        w.name_len  = name_len_q;
        w.value_len = value_len_q;
        parse_byte  = w;
    endfunction

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
            fail_total++;
        end
    endtask

    initial begin
        fail_total  = 0;
        words_total = 0;
        pairs_total = 0;
    end

    always @(posedge i_clk) begin : watch
        t_parse_word exp_w;
        if (!i_rst_n) begin
            phase_q     = PH_NLEN;
            idx_q       = '0;
            asm_q       = '0;
            name_len_q  = '0;
            value_len_q = '0;
            remain_q    = '0;
            expected_words.delete();
        end else begin
            // output side first: a word leaving now belongs to an earlier byte
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no byte waiting for it");
                    fail_total++;
                end else begin
                    exp_w = expected_words.pop_front();
                    check_field("byte_role", exp_w.role, o_byte_role);
                    check_field("out_byte", exp_w.data, o_out_byte);
                    check_field("name_length", exp_w.name_len[LENGTH_BITS-1:0],
                                o_name_length);
                    check_field("value_length", exp_w.value_len[LENGTH_BITS-1:0],
                                o_value_length);
                    check_field("lengths_valid", exp_w.marks.lengths_valid,
                                o_lengths_valid);
                    check_field("field_last", exp_w.marks.field_last, o_field_last);
                    check_field("pair_done", exp_w.marks.pair_done, o_pair_done);
                    words_total++;
                    if (exp_w.marks.pair_done) pairs_total++;
                end
            end
            if (i_in_valid && !o_in_stall) expected_words.push_back(parse_byte(i_in_byte));
        end
        o_pending       <= expected_words.size();
        o_fail_count    <= fail_total;
        o_words_checked <= words_total;
        o_pairs_done    <= pairs_total;
    end

endmodule

>>> verif/tb_fastcgi_param_pair_parser.sv
// Testbench top for the FastCGI name-value pair parser: clock, reset, byte stimulus,
// output back-pressure, watchdog and verdict. Depends on fcgi_pkg and the checker module.
module tb_fastcgi_param_pair_parser import fcgi_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LENGTH_BITS = 31;
    localparam int IDLE_LIMIT  = 3000;

    // Opening pairs: byte extremes as name and value data, empty name, empty value,
    // both empty, and four-byte lengths including a four-byte zero.
    localparam logic [8*25-1:0] OPENING = {
        8'h03, 8'h02, 8'h00, 8'hFF, 8'h41, 8'h7F, 8'h80,
        8'h00, 8'h01, 8'h55,
        8'h01, 8'h00, 8'hAA,
        8'h00, 8'h00,
        8'h80, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h02, 8'h12, 8'h34
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [BYTE_BITS-1:0]   i_in_byte;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [1:0]             o_byte_role;
    logic [BYTE_BITS-1:0]   o_out_byte;
    logic [LENGTH_BITS-1:0] o_name_length;
    logic [LENGTH_BITS-1:0] o_value_length;
    logic                   o_lengths_valid;
    logic                   o_field_last;
    logic                   o_pair_done;

    int fail_count;
    int pending;
    int words_checked;
    int pairs_done;

    logic [7:0] stream_q [$];
    bit         pressure_req  = 1'b0;
    bit         pressure_done = 1'b0;
    int         bytes_sent    = 0;

    always #6 i_clk = ~i_clk;

    fastcgi_param_pair_parser #(.LENGTH_BITS(LENGTH_BITS)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_role    (o_byte_role),
        .o_out_byte     (o_out_byte),
        .o_name_length  (o_name_length),
        .o_value_length (o_value_length),
        .o_lengths_valid(o_lengths_valid),
        .o_field_last   (o_field_last),
        .o_pair_done    (o_pair_done)
    );

    fastcgi_param_pair_checker #(.LENGTH_BITS(LENGTH_BITS)) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_role    (o_byte_role),
        .o_out_byte     (o_out_byte),
        .o_name_length  (o_name_length),
        .o_value_length (o_value_length),
        .o_lengths_valid(o_lengths_valid),
        .o_field_last   (o_field_last),
        .o_pair_done    (o_pair_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_words_checked(words_checked),
        .o_pairs_done   (pairs_done)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      pick_gap = 0;
        else if (r < 90) pick_gap = $urandom_range(1, 3);
        else             pick_gap = $urandom_range(6, 30);
    endfunction

    // Mostly short fields, now and then empty, near the short-form limit or four-byte.
    task automatic pick_length(output logic [30:0] len, output bit long_form);
        int r;
        r         = $urandom_range(0, 31);
        long_form = 1'b0;
        if (r < 4)       len = 31'd0;
        else if (r < 24) len = 31'($urandom_range(1, 5));
        else if (r < 28) len = 31'($urandom_range(6, 20));
        else if (r < 29) len = 31'($urandom_range(120, 127));
        else if (r < 31) begin
            len       = 31'($urandom_range(0, 10));
            long_form = 1'b1;
        end else begin
            len       = 31'($urandom_range(128, 160));
            long_form = 1'b1;
        end
    endtask

    task automatic queue_length(input logic [30:0] len, input bit long_form);
        if (long_form) begin
            stream_q.push_back({1'b1, len[30:24]});
            stream_q.push_back(len[23:16]);
            stream_q.push_back(len[15:8]);
            stream_q.push_back(len[7:0]);
        end else begin
            stream_q.push_back({1'b0, len[6:0]});
        end
    endtask

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_byte(input logic [7:0] b, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_stream(input bit no_gaps);
        logic [7:0] b;
        while (stream_q.size() > 0) begin
            b = stream_q.pop_front();
            send_byte(b, no_gaps ? 0 : pick_gap());
            bytes_sent++;
        end
    endtask

    initial begin : stimulus
        logic [30:0] nlen, vlen;
        bit          nlong, vlong, burst;
        int          pairs_sent;
        int          random_bytes;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_byte  <= '0;
        pairs_sent   = 0;
        random_bytes = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 24; i >= 0; i--) stream_q.push_back(OPENING[i*8 +: 8]);
        send_stream(1'b0);

        while (random_bytes < 1400) begin
            burst = ($urandom_range(0, 3) == 0);
            if (pairs_sent == 8) pressure_req = 1'b1;
            pick_length(nlen, nlong);
            pick_length(vlen, vlong);
            queue_length(nlen, nlong);
            queue_length(vlen, vlong);
            repeat (nlen + vlen) stream_q.push_back(8'($urandom_range(0, 255)));
            random_bytes += stream_q.size();
            // send without gaps in a burst and for the pair that requests the output hold
            send_stream(burst || (pressure_req && !pressure_done));
            pairs_sent++;
        end

        // Broken tail: an all-ones four-byte name length, a four-byte value length, then
        // raw bytes the pair never finishes on.
        queue_length(31'h7FFF_FFFF, 1'b1);
        queue_length(31'd256, 1'b1);
        repeat (100) stream_q.push_back(8'($urandom_range(0, 255)));
        send_stream(1'b0);
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes in %0d random pairs plus opening and broken tail;",
                 bytes_sent, pairs_sent);
        $display("checked %0d result words, %0d completed pairs, one long output hold.",
                 words_checked, pairs_done);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : sink
        bit stall_v;
        int n;
        int r;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (pressure_req && !pressure_done) begin
                stall_v       = 1'b1;
                n             = 150;
                pressure_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    stall_v = 1'b0;
                    n       = $urandom_range(1, 6);
                end else if (r < 60) begin
                    stall_v = 1'b0;
                    n       = $urandom_range(40, 80);
                end else if (r < 93) begin
                    stall_v = 1'b1;
                    n       = $urandom_range(1, 3);
                end else begin
                    stall_v = 1'b1;
                    n       = $urandom_range(8, 30);
                end
            end
            i_out_stall <= stall_v;
            repeat (n) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/fcgi_pkg.sv
rtl/fcgi_front.sv
rtl/fcgi_queue.sv
rtl/fastcgi_param_pair_parser.sv
verif/fastcgi_param_pair_checker.sv
verif/tb_fastcgi_param_pair_parser.sv
